// ----- sv/clmd_pkg.sv -----
// ----------------------------------------------------------------------------
// clmd_pkg: shared types and constants of the Content-Length deframer
// Field-parser states, length status codes, result status codes, the
// result bundle passed from the parser to the output register, and
// the lower-case header prefix.
// ----------------------------------------------------------------------------
package clmd_pkg;

   // Header line field parser
   typedef enum logic [2:0] {
      FS_MATCH,
      FS_SKIP,
      FS_SIGN,
      FS_DIGITS,
      FS_IGNORE,
      FS_DONE
   } field_state_type;

   // State of the most recent Content-Length value
   typedef enum logic [1:0] {
      HL_NONE,
      HL_VALID,
      HL_NEGATIVE,
      HL_OVERSIZE
   } length_status_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_BODY      = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NO_LENGTH = 3'd2,
      ST_CUT_SHORT = 3'd3,
      ST_TOO_LARGE = 3'd4
   } status_type;

   // One result item plus its valid flag
   typedef struct packed {
      logic       valid;
      logic [7:0] body_byte;
      logic       last_of_message;
      status_type status;
   } result_type;

   localparam int PREFIX_LEN = 15;

   // Character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Lower-case "content-length:" by position
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "c";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "l";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         4'd14:   ch = ":";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- sv/clmd_req_if.sv -----
// ----------------------------------------------------------------------------
// clmd_req_if: input byte channel
// Valid/ready channel carrying one stream byte or an end-of-input marker.
// ----------------------------------------------------------------------------
interface clmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_input;

   modport source (output valid, output byte_value, output end_of_input, input ready);
   modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

// ----- sv/clmd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// clmd_rsp_if: result channel
// Valid/ready channel carrying a body byte or a message status.
// ----------------------------------------------------------------------------
interface clmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       last_of_message;
   logic [2:0] status;

   modport source (output valid, output body_byte, output last_of_message,
                   output status, input ready);
   modport sink   (input valid, input body_byte, input last_of_message,
                   input status, output ready);
endinterface

// ----- sv/clmd_parser.sv -----
// ----------------------------------------------------------------------------
// clmd_parser: header/body parser state and next-state logic
// Holds all message parsing state. On step, consumes one item and
// produces at most one result (combinational, registered by the caller).
// ----------------------------------------------------------------------------
module clmd_parser
   import clmd_pkg::*;
#(
   parameter int LINE_CAP    = 1024,
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_value,
   input  logic       end_of_input,
   output result_type result
);

   localparam int LCW = $clog2(LINE_CAP);
   localparam int AW  = LENGTH_BITS + 1;
   localparam int PW  = LENGTH_BITS + 5;
   localparam logic [LCW-1:0] LINE_LAST = LCW'(LINE_CAP - 1);
   localparam logic [AW-1:0]  LIM       = AW'(1) << LENGTH_BITS;

   // state registers
   logic                   in_body_ff, in_body_in;
   logic                   crs_ff, crs_in;
   logic [LCW-1:0]         lcc_ff, lcc_in;
   field_state_type        fs_ff, fs_in;
   logic [3:0]             pidx_ff, pidx_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [LENGTH_BITS-1:0] hlen_ff, hlen_in;
   length_status_type      hst_ff, hst_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   // state after any line end, before the byte itself is handled
   logic                   mid_in_body, mid_crs, mid_neg;
   logic [LCW-1:0]         mid_lcc;
   field_state_type        mid_fs;
   logic [3:0]             mid_pidx;
   logic [AW-1:0]          mid_acc;
   logic [LENGTH_BITS-1:0] mid_hlen, mid_left;
   length_status_type      mid_hst;
   result_type             mid_res;
   logic                   feed_en, body_en;

   // line commit
   logic                   commit_en;
   length_status_type      commit_st, line_hst;
   logic [LENGTH_BITS-1:0] commit_len, line_hlen;

   // character classes
   logic [7:0]             lc;
   logic                   is_digit, is_space;
   logic [3:0]             dval;
   logic [PW-1:0]          prod;

   // Value of the current line if it were committed now
   always_comb begin
      commit_en = (lcc_ff != '0) && (fs_ff != FS_MATCH) && (fs_ff != FS_IGNORE);
      if (neg_ff && (acc_ff != '0)) begin
         commit_st  = HL_NEGATIVE;
         commit_len = '0;
      end else if (acc_ff >= LIM) begin
         commit_st  = HL_OVERSIZE;
         commit_len = '0;
      end else begin
         commit_st  = HL_VALID;
         commit_len = acc_ff[LENGTH_BITS-1:0];
      end
      line_hst  = commit_en ? commit_st : hst_ff;
      line_hlen = commit_en ? commit_len : hlen_ff;
   end

   // Character classes
   always_comb begin
      lc       = (byte_value inside {[CHAR_UP_A:CHAR_UP_Z]}) ? byte_value + CASE_DELTA
                                                             : byte_value;
      is_digit = byte_value inside {[CHAR_ZERO:CHAR_NINE]};
      is_space = byte_value inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
      dval     = 4'(byte_value - CHAR_ZERO);
      prod     = (PW'(mid_acc) << 3) + (PW'(mid_acc) << 1) + PW'(dval);
   end

   // Line-end and end-of-input handling
   always_comb begin
      mid_in_body = in_body_ff;
      mid_crs     = crs_ff;
      mid_lcc     = lcc_ff;
      mid_fs      = fs_ff;
      mid_pidx    = pidx_ff;
      mid_acc     = acc_ff;
      mid_neg     = neg_ff;
      mid_hlen    = hlen_ff;
      mid_hst     = hst_ff;
      mid_left    = left_ff;
      mid_res     = '{valid: 1'b0, body_byte: 8'h00, last_of_message: 1'b0,
                      status: ST_BODY};
      feed_en     = 1'b0;
      body_en     = 1'b0;

      if (step) begin
         if (end_of_input) begin
            // stream ended: report and return to reset state
            mid_in_body = 1'b0;
            mid_crs     = 1'b0;
            mid_lcc     = '0;
            mid_fs      = FS_MATCH;
            mid_pidx    = '0;
            mid_acc     = '0;
            mid_neg     = 1'b0;
            mid_hlen    = '0;
            mid_hst     = HL_NONE;
            mid_left    = '0;
            mid_res.valid = 1'b1;
            if (in_body_ff) begin
               mid_res.status = ST_CUT_SHORT;
            end else begin
               case (line_hst)
                  HL_VALID: begin
                     if (line_hlen == '0) begin
                        mid_res.status          = ST_EMPTY;
                        mid_res.last_of_message = 1'b1;
                     end else begin
                        mid_res.status = ST_CUT_SHORT;
                     end
                  end
                  HL_OVERSIZE: mid_res.status = ST_TOO_LARGE;
                  default:     mid_res.status = ST_NO_LENGTH;
               endcase
            end
         end else if (in_body_ff) begin
            body_en = 1'b1;
         end else if (byte_value == CHAR_CR) begin
            mid_crs = 1'b1;
         end else if ((byte_value == CHAR_LF) || crs_ff) begin
            // line ends here (LF, or byte after a lone CR)
            mid_crs = 1'b0;
            if (lcc_ff == '0) begin
               // blank line: headers done
               mid_fs   = FS_MATCH;
               mid_pidx = '0;
               mid_acc  = '0;
               mid_neg  = 1'b0;
               if ((hst_ff == HL_VALID) && (hlen_ff != '0)) begin
                  mid_in_body = 1'b1;
                  mid_left    = hlen_ff;
               end else begin
                  mid_hlen      = '0;
                  mid_hst       = HL_NONE;
                  mid_left      = '0;
                  mid_res.valid = 1'b1;
                  case (hst_ff)
                     HL_VALID: begin
                        mid_res.status          = ST_EMPTY;
                        mid_res.last_of_message = 1'b1;
                     end
                     HL_OVERSIZE: mid_res.status = ST_TOO_LARGE;
                     default:     mid_res.status = ST_NO_LENGTH;
                  endcase
               end
            end else begin
               mid_hst  = line_hst;
               mid_hlen = line_hlen;
               mid_lcc  = '0;
               mid_fs   = FS_MATCH;
               mid_pidx = '0;
               mid_acc  = '0;
               mid_neg  = 1'b0;
            end
            // after a lone CR the byte itself still has to be handled
            if (byte_value != CHAR_LF) begin
               body_en = mid_in_body;
               feed_en = !mid_in_body;
            end
         end else begin
            feed_en = 1'b1;
         end
      end
   end

   // Header character feed and body byte pass-through
   always_comb begin
      in_body_in = mid_in_body;
      crs_in     = mid_crs;
      lcc_in     = mid_lcc;
      fs_in      = mid_fs;
      pidx_in    = mid_pidx;
      acc_in     = mid_acc;
      neg_in     = mid_neg;
      hlen_in    = mid_hlen;
      hst_in     = mid_hst;
      left_in    = mid_left;
      result     = mid_res;

      if (feed_en && (mid_lcc != LINE_LAST)) begin
         lcc_in = mid_lcc + LCW'(1);
         case (mid_fs)
            FS_MATCH: begin
               if ((mid_pidx < 4'(PREFIX_LEN)) && (lc == prefix_char(mid_pidx))) begin
                  pidx_in = mid_pidx + 4'd1;
                  if (mid_pidx == 4'(PREFIX_LEN - 1)) begin
                     fs_in = FS_SKIP;
                  end
               end else begin
                  fs_in = FS_IGNORE;
               end
            end
            FS_SKIP: begin
               if (is_space) begin
                  fs_in = FS_SKIP;
               end else if (byte_value == CHAR_PLUS) begin
                  fs_in = FS_SIGN;
               end else if (byte_value == CHAR_MINUS) begin
                  neg_in = 1'b1;
                  fs_in  = FS_SIGN;
               end else if (is_digit) begin
                  acc_in = AW'(dval);
                  fs_in  = FS_DIGITS;
               end else begin
                  fs_in = FS_DONE;
               end
            end
            FS_SIGN, FS_DIGITS: begin
               if (is_digit) begin
                  // saturate at 2^LENGTH_BITS
                  acc_in = (prod > PW'(LIM)) ? LIM : prod[AW-1:0];
                  fs_in  = FS_DIGITS;
               end else begin
                  fs_in = FS_DONE;
               end
            end
            default: fs_in = mid_fs;
         endcase
      end

      if (body_en) begin
         result.valid           = 1'b1;
         result.body_byte       = byte_value;
         result.status          = ST_BODY;
         result.last_of_message = (mid_left <= LENGTH_BITS'(1));
         left_in = (mid_left == '0) ? '0 : mid_left - LENGTH_BITS'(1);
         if (mid_left <= LENGTH_BITS'(1)) begin
            // final body byte: back to the header phase
            in_body_in = 1'b0;
            crs_in     = 1'b0;
            lcc_in     = '0;
            fs_in      = FS_MATCH;
            pidx_in    = '0;
            acc_in     = '0;
            neg_in     = 1'b0;
            hlen_in    = '0;
            hst_in     = HL_NONE;
            left_in    = '0;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
         crs_ff     <= 1'b0;
         lcc_ff     <= '0;
         fs_ff      <= FS_MATCH;
         pidx_ff    <= '0;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         hlen_ff    <= '0;
         hst_ff     <= HL_NONE;
         left_ff    <= '0;
      end else begin
         in_body_ff <= in_body_in;
         crs_ff     <= crs_in;
         lcc_ff     <= lcc_in;
         fs_ff      <= fs_in;
         pidx_ff    <= pidx_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         hlen_ff    <= hlen_in;
         hst_ff     <= hst_in;
         left_ff    <= left_in;
      end
   end

   // Body phase always has bytes to go
   assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> (left_ff != '0))
      else $error("body phase with no bytes left");

   // Line state is clean during the body
   assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> ((lcc_ff == '0) && (fs_ff == FS_MATCH) && (pidx_ff == '0)))
      else $error("line state not cleared in body phase");

   // Prefix index stays inside the prefix while matching
   assert property (@(posedge clock) disable iff (reset)
      (fs_ff == FS_MATCH) |-> (pidx_ff < 4'(PREFIX_LEN)))
      else $error("prefix index overrun");

   // Accumulator never exceeds its saturation value
   assert property (@(posedge clock) disable iff (reset)
      acc_ff <= LIM)
      else $error("length accumulator above limit");

   // A message end leaves the parser in the header phase with no length
   assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && result.last_of_message)
         |=> (!in_body_ff && (hst_ff == HL_NONE)))
      else $error("state not cleared after message end");

endmodule

// ----- sv/content_length_message_deframer.sv -----
// ----------------------------------------------------------------------------
// content_length_message_deframer: Content-Length framed message splitter
// An accepted item passes the input register; its result is then registered in the output register.
// Throughput: 1 item per cycle while the output slot is free or being read.
// An item with no result still passes through the input register.
// Reset (synchronous): parser returns to the header phase, no length held,
// both the input and output registers empty.
// Parses header lines, picks up the Content-Length value and passes the
// body bytes on, flagging the last one or reporting framing errors.
// ----------------------------------------------------------------------------
module content_length_message_deframer
   import clmd_pkg::*;
#(
   parameter int LINE_CAP    = 1024,
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   clmd_req_if.sink    req_if,
   clmd_rsp_if.source  rsp_if
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_eoi_ff, s1_eoi_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       req_take;
   result_type step_res;

   // Item moves from input register into the parser when the output slot frees
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;

   clmd_parser #(
      .LINE_CAP    (LINE_CAP),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .byte_value   (s1_byte_ff),
      .end_of_input (s1_eoi_ff),
      .result       (step_res)
   );

   // Input register next state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_eoi_in   = s1_eoi_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_if.byte_value;
         s1_eoi_in   = req_if.end_of_input;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Output register next state
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_in       = out_ff;
      if (advance && step_res.valid) begin
         out_valid_in = 1'b1;
         out_in       = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_eoi_ff  <= s1_eoi_in;
      out_ff     <= out_in;
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.body_byte       = out_ff.body_byte;
   assign rsp_if.last_of_message = out_ff.last_of_message;
   assign rsp_if.status          = out_ff.status;

endmodule

// ----- tb/clmd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmd_checker: deframer result predictor and scoreboard
// Watches both channels. Every accepted input item runs through a local
// model of the header parser and body counter, which queues the result it
// should cause. Every accepted result is compared field by field with the
// oldest queued one. Failures, backlog and traffic counts go to the top.
// ----------------------------------------------------------------------------
module clmd_checker
   import clmd_pkg::*;
#(
   parameter int LINE_CAP    = 1024,
   parameter int LENGTH_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   clmd_req_if  req,
   clmd_rsp_if  rsp,
   output int   fail_count,
   output int   outstanding,
   output int   item_count,
   output int   result_count,
   output int   body_count,
   output int   empty_count,
   output int   fault_count
);

   localparam logic [8*PREFIX_LEN-1:0] LENGTH_KEY = "content-length:";
   localparam logic [LENGTH_BITS+4:0]  LEN_LIMIT  = {4'b0, 1'b1, {LENGTH_BITS{1'b0}}};

   typedef struct packed {
      logic [7:0] body_byte;
      logic       last_of_message;
      status_type status;
   } deframed_type;

   deframed_type expected_q[$];
   deframed_type oldest;

   // Parser copy
   logic                   in_body;
   logic                   cr_pending;
   int                     line_len;
   field_state_type        field_st;
   int                     key_pos;
   logic [LENGTH_BITS:0]   value_acc;
   logic                   value_neg;
   logic [LENGTH_BITS-1:0] frame_len;
   length_status_type      frame_len_st;
   logic [LENGTH_BITS-1:0] body_left;

   function automatic void expect_result(input logic [7:0] b, input logic last,
                                         input status_type st);
      deframed_type r;
      r.body_byte       = b;
      r.last_of_message = last;
      r.status          = st;
      expected_q.push_back(r);
   endfunction

   function automatic void clear_line();
      line_len  = 0;
      field_st  = FS_MATCH;
      key_pos   = 0;
      value_acc = '0;
      value_neg = 1'b0;
   endfunction

   function automatic void clear_message();
      clear_line();
      in_body      = 1'b0;
      cr_pending   = 1'b0;
      frame_len    = '0;
      frame_len_st = HL_NONE;
      body_left    = '0;
   endfunction

   // One header character through the field parser
   function automatic void scan_char(input logic [7:0] c);
      logic [7:0]             lc;
      logic                   is_digit;
      logic [LENGTH_BITS+4:0] next_acc;
      lc       = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_DELTA : c;
      is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      // bytes past the line cap are dropped
      if (line_len >= LINE_CAP - 1) return;
      line_len++;
      case (field_st)
         FS_MATCH: begin
            if (key_pos < PREFIX_LEN && lc == LENGTH_KEY[8*(PREFIX_LEN-1-key_pos) +: 8]) begin
               key_pos++;
               if (key_pos == PREFIX_LEN) field_st = FS_SKIP;
            end else begin
               field_st = FS_IGNORE;
            end
         end
         FS_SKIP: begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
               field_st = FS_SKIP;
            end else if (c == CHAR_PLUS) begin
               field_st = FS_SIGN;
            end else if (c == CHAR_MINUS) begin
               value_neg = 1'b1;
               field_st  = FS_SIGN;
            end else if (is_digit) begin
               value_acc = (LENGTH_BITS+1)'(c - CHAR_ZERO);
               field_st  = FS_DIGITS;
            end else begin
               field_st = FS_DONE;
            end
         end
         FS_SIGN, FS_DIGITS: begin
            if (is_digit) begin
               // saturate at the limit so the value never wraps
               next_acc  = value_acc * 10 + (c - CHAR_ZERO);
               if (next_acc > LEN_LIMIT) next_acc = LEN_LIMIT;
               value_acc = next_acc[LENGTH_BITS:0];
               field_st  = FS_DIGITS;
            end else begin
               field_st = FS_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // A finished length header replaces the held length
   function automatic void commit_value();
      if (field_st == FS_MATCH || field_st == FS_IGNORE) return;
      if (value_neg && value_acc != 0) begin
         frame_len_st = HL_NEGATIVE;
         frame_len    = '0;
      end else if (value_acc >= LEN_LIMIT) begin
         frame_len_st = HL_OVERSIZE;
         frame_len    = '0;
      end else begin
         frame_len_st = HL_VALID;
         frame_len    = value_acc[LENGTH_BITS-1:0];
      end
   endfunction

   // Line end; a blank line closes the headers. Returns 1 if a result came.
   function automatic logic close_line();
      if (line_len != 0) begin
         commit_value();
         clear_line();
         return 1'b0;
      end
      if (frame_len_st == HL_VALID && frame_len != 0) begin
         clear_line();
         in_body   = 1'b1;
         body_left = frame_len;
         return 1'b0;
      end
      if (frame_len_st == HL_VALID) begin
         clear_message();
         expect_result(8'h00, 1'b1, ST_EMPTY);
      end else if (frame_len_st == HL_OVERSIZE) begin
         clear_message();
         expect_result(8'h00, 1'b0, ST_TOO_LARGE);
      end else begin
         clear_message();
         expect_result(8'h00, 1'b0, ST_NO_LENGTH);
      end
      return 1'b1;
   endfunction

   function automatic void pass_body(input logic [7:0] c);
      logic last;
      if (body_left != 0) body_left--;
      last = (body_left == 0);
      if (last) clear_message();
      expect_result(c, last, ST_BODY);
   endfunction

   function automatic void deframe_item(input logic [7:0] c, input logic eoi);
      logic emitted;
      logic empty;
      // end of stream: close out whatever is pending
      if (eoi) begin
         if (in_body) begin
            clear_message();
            expect_result(8'h00, 1'b0, ST_CUT_SHORT);
            return;
         end
         if (line_len > 0) commit_value();
         if (frame_len_st == HL_VALID) begin
            empty = (frame_len == 0);
            clear_message();
            if (empty) expect_result(8'h00, 1'b1, ST_EMPTY);
            else expect_result(8'h00, 1'b0, ST_CUT_SHORT);
         end else if (frame_len_st == HL_OVERSIZE) begin
            clear_message();
            expect_result(8'h00, 1'b0, ST_TOO_LARGE);
         end else begin
            clear_message();
            expect_result(8'h00, 1'b0, ST_NO_LENGTH);
         end
         return;
      end
      if (in_body) begin
         pass_body(c);
         return;
      end
      if (c == CHAR_CR) begin
         cr_pending = 1'b1;
         return;
      end
      if (c == CHAR_LF) begin
         cr_pending = 1'b0;
         emitted    = close_line();
         return;
      end
      // lone CR: this byte starts the next line, or the body
      if (cr_pending) begin
         cr_pending = 1'b0;
         emitted    = close_line();
         if (!emitted && in_body) begin
            pass_body(c);
            return;
         end
      end
      scan_char(c);
   endfunction

   // Predict on accepted items, compare accepted results
   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         expected_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            item_count++;
            deframe_item(req.byte_value, req.end_of_input);
         end
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (rsp.status == ST_BODY) body_count++;
            else if (rsp.status == ST_EMPTY) empty_count++;
            else fault_count++;
            if (expected_q.size() == 0) begin
               $error("unexpected result item: body_byte %h last_of_message %b status %0d",
                      rsp.body_byte, rsp.last_of_message, rsp.status);
               fail_count++;
            end else begin
               oldest = expected_q.pop_front();
               if (rsp.body_byte !== oldest.body_byte) begin
                  $error("body_byte mismatch: expected %h, actual %h",
                         oldest.body_byte, rsp.body_byte);
                  fail_count++;
               end
               if (rsp.last_of_message !== oldest.last_of_message) begin
                  $error("last_of_message mismatch: expected %b, actual %b",
                         oldest.last_of_message, rsp.last_of_message);
                  fail_count++;
               end
               if (rsp.status !== oldest.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         oldest.status, rsp.status);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_q.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Content-Length deframer
// Feeds a short hand-built stream, then randomly built messages: mixed
// header lines with every line ending, length headers in random case with
// signs, blanks, saturating and negative values, overlong lines, cut bodies
// and end markers, plus raw noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench
   import clmd_pkg::*;
();

   localparam int LINE_CAP     = 1024;
   localparam int LENGTH_BITS  = 32;
   localparam int RANDOM_ITEMS = 1500;
   localparam logic [8*PREFIX_LEN-1:0] KEY_TEXT = "Content-Length:";

   typedef enum {EOL_LF, EOL_CRLF, EOL_CRCRLF, EOL_CR} eol_kind_type;
   typedef enum {
      MSG_NORMAL,
      MSG_NEGATIVE,
      MSG_OVERSIZE,
      MSG_MISSING,
      MSG_NO_DIGITS,
      MSG_CUT_BODY,
      MSG_CUT_HEADER,
      MSG_NOISE
   } msg_kind_type;

   typedef struct {
      logic [7:0] value;
      logic       eoi;
   } stream_item_type;

   logic            clock;
   logic            reset;
   bit              steady;
   int              sent_total;
   stream_item_type stream_q[$];

   int fail_count, outstanding, item_count, result_count;
   int body_count, empty_count, fault_count;

   clmd_req_if req_ch ();
   clmd_rsp_if rsp_ch ();

   content_length_message_deframer #(
      .LINE_CAP    (LINE_CAP),
      .LENGTH_BITS (LENGTH_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   clmd_checker #(
      .LINE_CAP    (LINE_CAP),
      .LENGTH_BITS (LENGTH_BITS)
   ) frame_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .item_count   (item_count),
      .result_count (result_count),
      .body_count   (body_count),
      .empty_count  (empty_count),
      .fault_count  (fault_count)
   );

   // Clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---- stream building ----

   task automatic put_byte(input logic [7:0] b);
      stream_q.push_back('{value: b, eoi: 1'b0});
   endtask

   task automatic put_end();
      stream_q.push_back('{value: 8'($urandom_range(0, 255)), eoi: 1'b1});
   endtask

   task automatic put_text(input string s);
      foreach (s[i]) put_byte(s[i]);
   endtask

   task automatic put_eol(input eol_kind_type k);
      case (k)
         EOL_LF: put_byte(CHAR_LF);
         EOL_CRLF: begin
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
         end
         EOL_CRCRLF: begin
            put_byte(CHAR_CR);
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
         end
         default: put_byte(CHAR_CR);
      endcase
   endtask

   // a lone CR only where the caller allows it
   function automatic eol_kind_type pick_eol(input bit allow_cr);
      return allow_cr ? eol_kind_type'($urandom_range(0, 3))
                      : eol_kind_type'($urandom_range(0, 2));
   endfunction

   // header text: mostly printable, some NUL and high bytes
   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   // first count characters of the key, letters in random case
   task automatic put_key(input int count);
      logic [7:0] ch;
      logic [7:0] lower;
      for (int i = 0; i < count; i++) begin
         ch    = KEY_TEXT[8*(PREFIX_LEN-1-i) +: 8];
         lower = ch | CASE_DELTA;
         if (lower >= "a" && lower <= "z" && $urandom_range(0, 1)) ch = ch ^ CASE_DELTA;
         put_byte(ch);
      end
   endtask

   task automatic put_blanks(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 3);
         put_byte(r == 0 ? CHAR_SPACE : r == 1 ? CHAR_TAB : r == 2 ? CHAR_VT : CHAR_FF);
      end
   endtask

   task automatic put_digits(input longint unsigned value);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CHAR_ZERO + 8'(value % 10));
         value = value / 10;
      end while (value != 0);
      foreach (digits[i]) put_byte(digits[i]);
   endtask

   // length header without its line ending; sign 0 means none
   task automatic put_length_line(input logic [7:0] sign, input bit with_digits,
                                  input longint unsigned value, input int nines);
      put_key(PREFIX_LEN);
      put_blanks($urandom_range(0, 2));
      if (sign != 8'h00) put_byte(sign);
      if (with_digits) begin
         if ($urandom_range(0, 4) == 0) put_byte(CHAR_ZERO);
         put_digits(value);
         repeat (nines) put_byte(CHAR_NINE);
      end
      if ($urandom_range(0, 4) == 0) begin
         put_byte(CHAR_SPACE);
         put_byte(text_char());
      end
   endtask

   // unrelated header, sometimes a near miss on the key
   task automatic put_other_line();
      if ($urandom_range(0, 2) == 0) put_key($urandom_range(1, PREFIX_LEN - 1));
      repeat ($urandom_range(1, 12)) put_byte(text_char());
   endtask

   task automatic put_message(input msg_kind_type kind);
      int         n_other;
      int         n_len;
      int         lines;
      int         body_len;
      int         cut;
      int         r;
      logic [7:0] sign;
      if (kind == MSG_NOISE) begin
         repeat ($urandom_range(1, 16)) begin
            r = $urandom_range(0, 3);
            put_byte(r == 0 ? CHAR_CR : r == 1 ? CHAR_LF : 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1)) put_end();
         return;
      end
      n_other  = $urandom_range(0, 2);
      n_len    = (kind == MSG_MISSING) ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
      body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
      if (kind != MSG_NORMAL && kind != MSG_CUT_BODY && kind != MSG_CUT_HEADER) body_len = 0;
      lines = n_other + n_len;
      for (int i = 0; i < lines; i++) begin
         if (n_len > 0 && (n_other == 0 || $urandom_range(0, 1))) begin
            if (n_len == 2) begin
               // earlier header, overridden by the later one
               put_length_line($urandom_range(0, 3) == 0 ? CHAR_MINUS : 8'h00, 1'b1,
                               $urandom_range(0, 99), 0);
            end else begin
               case (kind)
                  MSG_NEGATIVE: put_length_line(CHAR_MINUS, 1'b1, $urandom_range(1, 999), 0);
                  MSG_OVERSIZE: begin
                     if ($urandom_range(0, 1))
                        put_length_line($urandom_range(0, 1) ? CHAR_PLUS : 8'h00, 1'b1,
                                        (64'd1 << LENGTH_BITS) + $urandom_range(0, 1000), 0);
                     else
                        put_length_line(8'h00, 1'b1, $urandom_range(1, 9), $urandom_range(9, 14));
                  end
                  MSG_NO_DIGITS: begin
                     r = $urandom_range(0, 2);
                     put_length_line(r == 0 ? 8'h00 : r == 1 ? CHAR_PLUS : CHAR_MINUS,
                                     1'b0, 0, 0);
                  end
                  default: begin
                     sign = ($urandom_range(0, 4) == 0) ? CHAR_PLUS : 8'h00;
                     if (body_len == 0 && $urandom_range(0, 1)) sign = CHAR_MINUS;
                     put_length_line(sign, 1'b1, body_len, 0);
                  end
               endcase
            end
            n_len--;
         end else begin
            put_other_line();
            n_other--;
         end
         put_eol(pick_eol(i < lines - 1));
      end
      // stream ends inside the headers
      if (kind == MSG_CUT_HEADER) begin
         r = $urandom_range(0, 2);
         if (r == 0) repeat ($urandom_range(1, 6)) put_byte(text_char());
         else if (r == 1) put_length_line(8'h00, 1'b1, $urandom_range(0, 5), 0);
         put_end();
         return;
      end
      put_eol(pick_eol(1'b1));
      if (kind == MSG_CUT_BODY) begin
         cut = (body_len == 0) ? 0 : $urandom_range(0, body_len - 1);
         repeat (cut) put_byte(8'($urandom_range(0, 255)));
         put_end();
         return;
      end
      repeat (body_len) put_byte(8'($urandom_range(0, 255)));
   endtask

   // Length header running past the line cap; the digits straddle it
   task automatic put_long_message();
      int spaces;
      int body_len;
      spaces = $urandom_range(1004, 1009);
      put_key(PREFIX_LEN);
      repeat (spaces) put_byte(CHAR_SPACE);
      put_text("20xxxxxxxx");
      put_eol(pick_eol(1'b0));
      put_eol(pick_eol(1'b0));
      body_len = (spaces <= 1006) ? 20 : (spaces == 1007) ? 2 : 0;
      repeat (body_len) put_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic msg_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return MSG_NORMAL;
      if (r < 67) return MSG_NEGATIVE;
      if (r < 73) return MSG_OVERSIZE;
      if (r < 79) return MSG_MISSING;
      if (r < 84) return MSG_NO_DIGITS;
      if (r < 91) return MSG_CUT_BODY;
      if (r < 96) return MSG_CUT_HEADER;
      return MSG_NOISE;
   endfunction

   // ---- driving ----

   task automatic send_item(input stream_item_type it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.byte_value   <= it.value;
      req_ch.end_of_input <= it.eoi;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      // switch between idling and back-to-back stretches
      sent_total++;
      if (sent_total % 64 == 0) steady = ($urandom_range(0, 3) == 0);
   endtask

   task automatic flush_stream();
      stream_item_type it;
      while (stream_q.size() > 0) begin
         it = stream_q.pop_front();
         send_item(it);
      end
   endtask

   // hold off until every predicted result has arrived
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Result side: random stall before each item
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      int sent_random;
      req_ch.valid        = 1'b0;
      req_ch.byte_value   = 8'h00;
      req_ch.end_of_input = 1'b0;
      reset               = 1'b1;
      sent_random         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty stream, blank line with no length, then a two byte
      // body behind a lone CR, carrying the byte extremes
      put_end();
      put_byte(CHAR_LF);
      put_text("CONTENT-length:+2");
      put_eol(EOL_CRLF);
      put_byte(CHAR_CR);
      put_byte(8'hFF);
      put_byte(8'h00);
      flush_stream();
      drain();

      // random phase opens with one header line past the line cap
      put_long_message();
      sent_random += stream_q.size();
      flush_stream();

      // random messages
      while (sent_random < RANDOM_ITEMS) begin
         put_message(pick_kind());
         sent_random += stream_q.size();
         flush_stream();
      end
      put_end();
      flush_stream();

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("Covered %0d input items: all line endings, long lines, signed, saturating",
               item_count);
      $display("and missing lengths, cut bodies and headers; %0d results", result_count);
      $display("(%0d body, %0d empty, %0d errors)", body_count, empty_count, fault_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
